// File: rtl/krmt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krmt_pkg
// Shared constants, status codes and queue word type for the mapping table.
// ----------------------------------------------------------------------------
package krmt_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int MAX_ELEMENTS  = 64;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
    localparam int ELEM_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W         = $clog2(MAX_ELEMENTS + 1);
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [3:0] ST_HIT          = 4'd0;
    localparam logic [3:0] ST_RANGE_HIT    = 4'd1;
    localparam logic [3:0] ST_OUT_OF_RANGE = 4'd2;
    localparam logic [3:0] ST_AMBIGUOUS    = 4'd3;
    localparam logic [3:0] ST_MISS         = 4'd4;
    localparam logic [3:0] ST_BAD_PACKET   = 4'd5;
    localparam logic [3:0] ST_INSERTED     = 4'd6;
    localparam logic [3:0] ST_REPLACED     = 4'd7;
    localparam logic [3:0] ST_EVICTED      = 4'd8;
    localparam logic [3:0] ST_IGNORED      = 4'd9;

    localparam logic [31:0] NOT_FOUND = 32'hFFFF_FFFF;

    typedef enum logic [1:0]
    {
        OP_LOOKUP = 2'd0,
        OP_COMMIT = 2'd1,
        OP_IGNORE = 2'd2,
        OP_BADPKT = 2'd3
    } op_t;

    typedef struct packed
    {
        op_t              op;
        logic [63:0]      key;
        logic [CNT_W-1:0] count;
        logic [31:0]      start;
        logic [31:0]      ordinal;
        logic [31:0]      pstart;
        logic [31:0]      pcount;
        logic [CNT_W-1:0] fill;
    } cmd_t;

endpackage
`default_nettype wire

// File: rtl/krmt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krmt_front
// Accept input words, stage element values, classify into commands.
// ----------------------------------------------------------------------------
module krmt_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic                          action,
    input  wire logic [63:0]                   proxy,
    input  wire logic [31:0]                   entry_count,
    input  wire logic [31:0]                   output_start,
    input  wire logic [31:0]                   element_value,
    input  wire logic                          last_element,
    input  wire logic [31:0]                   ordinal,
    input  wire logic [31:0]                   packet_start,
    input  wire logic [31:0]                   packet_count,
    output      logic                          cmd_valid,
    input  wire logic                          cmd_ready,
    output      krmt_pkg::cmd_t                cmd,
    input  wire logic [krmt_pkg::ELEM_W-1:0]   stg_raddr,
    output      logic [31:0]                   stg_rdata,
    input  wire logic                          stg_release
);

    logic [31:0]                     stg_mem [krmt_pkg::MAX_ELEMENTS];
    logic [krmt_pkg::CNT_W-1:0]      fill_reg, fill_next;
    logic                            busy_reg, busy_next;
    logic                            acc, is_pub, is_last;
    logic [32:0]                     diff;
    logic                            bad;

    // hold staging until the engine has copied it
    assign in_ready  = cmd_ready && !busy_reg;
    assign acc       = in_valid && in_ready;
    assign is_pub    = !action;
    assign is_last   = is_pub && last_element;
    assign cmd_valid = acc && (action || last_element);
    assign diff      = {1'b0, ordinal} - {1'b0, packet_start};
    assign bad       = diff[32] || (diff[31:0] >= packet_count);

    always_comb
    begin
        cmd         = '0;
        cmd.key     = proxy;
        cmd.start   = output_start;
        cmd.ordinal = ordinal;
        cmd.pstart  = packet_start;
        cmd.pcount  = packet_count;
        cmd.fill    = (is_pub && fill_reg < krmt_pkg::CNT_W'(krmt_pkg::MAX_ELEMENTS))
                      ? fill_reg + 1'b1 : fill_reg;
        cmd.count   = (entry_count > 32'(krmt_pkg::MAX_ELEMENTS))
                      ? krmt_pkg::CNT_W'(krmt_pkg::MAX_ELEMENTS)
                      : krmt_pkg::CNT_W'(entry_count);
        if (action)
            cmd.op = bad ? krmt_pkg::OP_BADPKT : krmt_pkg::OP_LOOKUP;
        else if (proxy == 64'd0 || entry_count == 32'd0)
            cmd.op = krmt_pkg::OP_IGNORE;
        else
            cmd.op = krmt_pkg::OP_COMMIT;
    end

    always_comb
    begin
        fill_next = fill_reg;
        busy_next = busy_reg;
        if (acc && is_pub)
            fill_next = is_last ? '0 : cmd.fill;
        if (acc && is_last && cmd.op == krmt_pkg::OP_COMMIT)
            busy_next = 1'b1;
        else if (stg_release)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && is_pub && fill_reg < krmt_pkg::CNT_W'(krmt_pkg::MAX_ELEMENTS))
            stg_mem[fill_reg[krmt_pkg::ELEM_W-1:0]] <= element_value;
        stg_rdata <= stg_mem[stg_raddr];
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= krmt_pkg::CNT_W'(krmt_pkg::MAX_ELEMENTS))
        else $error("staging fill overflow");
    a_fill_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && is_last) |=> fill_reg == '0)
        else $error("fill not cleared on commit");
    a_busy_block: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !in_ready)
        else $error("accept while commit pending");
`endif

endmodule
`default_nettype wire

// File: rtl/krmt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krmt_queue
// Short command queue between classifier and table engine.
// ----------------------------------------------------------------------------
module krmt_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_valid,
    output      logic           wr_ready,
    input  wire krmt_pkg::cmd_t wr_data,
    output      logic           rd_valid,
    input  wire logic           rd_ready,
    output      krmt_pkg::cmd_t rd_data
);

    localparam int PW = $clog2(krmt_pkg::QUEUE_DEPTH);

    krmt_pkg::cmd_t  q_reg [krmt_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [PW:0]     n_reg;
    logic            push, pop;

    assign wr_ready = n_reg < (PW+1)'(krmt_pkg::QUEUE_DEPTH);
    assign rd_valid = n_reg != '0;
    assign rd_data  = q_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            n_reg  <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            n_reg <= n_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= wr_data;
    end

endmodule
`default_nettype wire

// File: rtl/krmt_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// krmt_engine
// Scan slots for commit and lookup, copy staging, read index memory.
// ----------------------------------------------------------------------------
module krmt_engine
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    output      logic                          cmd_ready,
    input  wire krmt_pkg::cmd_t                cmd,
    output      logic [krmt_pkg::ELEM_W-1:0]   stg_raddr,
    input  wire logic [31:0]                   stg_rdata,
    output      logic                          stg_release,
    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic [31:0]                   index_value,
    output      logic [3:0]                    status
);

    localparam int SW = krmt_pkg::SLOT_W;
    localparam int EW = krmt_pkg::ELEM_W;
    localparam int CW = krmt_pkg::CNT_W;

    typedef enum logic [8:0]
    {
        S_IDLE  = 9'b000000001,
        S_KEY   = 9'b000000010,
        S_RANGE = 9'b000000100,
        S_IREAD = 9'b000001000,
        S_IWAIT = 9'b000010000,
        S_CSCAN = 9'b000100000,
        S_COPY  = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_WAIT  = 9'b100000000
    } state_t;

    logic [63:0]   key_mem   [krmt_pkg::TABLE_ENTRIES];
    logic [31:0]   start_mem [krmt_pkg::TABLE_ENTRIES];
    logic [CW-1:0] cnt_mem   [krmt_pkg::TABLE_ENTRIES];
    logic [31:0]   idx_mem   [krmt_pkg::TABLE_ENTRIES * krmt_pkg::MAX_ELEMENTS];
    logic [krmt_pkg::TABLE_ENTRIES-1:0] vld_reg;

    state_t          state_reg;
    krmt_pkg::cmd_t  c_reg;
    logic [SW:0]     i_reg;
    logic [SW-1:0]   sel_reg;
    logic [EW-1:0]   off_reg;
    logic [CW:0]     k_reg;
    logic            kfound_reg, have_reg, free_reg, hitk_reg, copyv_reg;
    logic [SW-1:0]   free_slot_reg;
    logic [31:0]     val_reg, rd_reg;
    logic [3:0]      st_reg;

    logic [63:0]     key_q;
    logic [31:0]     start_q;
    logic [CW-1:0]   cnt_q;
    logic            vld_q;

    logic [SW-1:0]   ra, ps;
    logic [32:0]     od;
    logic            in_slice, kmatch, rmatch;

    // slot data arrives in the cycle after its address; ps is the slot on the bus
    assign ra          = i_reg[SW-1:0];
    assign ps          = SW'(i_reg - 1'b1);
    assign od          = {1'b0, c_reg.ordinal} - {1'b0, start_q};
    assign in_slice    = !od[32] && od[31:0] < 32'(cnt_q);
    assign kmatch      = vld_q && key_q == c_reg.key;
    assign rmatch      = vld_q && start_q == c_reg.pstart && 32'(cnt_q) <= c_reg.pcount;
    assign cmd_ready   = state_reg == S_IDLE;
    assign out_valid   = state_reg == S_OUT;
    assign index_value = val_reg;
    assign status      = st_reg;
    assign stg_raddr   = k_reg[EW-1:0];
    assign stg_release = state_reg == S_COPY && k_reg == (CW+1)'(krmt_pkg::MAX_ELEMENTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vld_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        i_reg      <= '0;
                        kfound_reg <= 1'b0;
                        have_reg   <= 1'b0;
                        free_reg   <= 1'b0;
                        hitk_reg   <= 1'b0;
                        case (cmd.op)
                            krmt_pkg::OP_LOOKUP: state_reg <= S_KEY;
                            krmt_pkg::OP_COMMIT: state_reg <= S_CSCAN;
                            krmt_pkg::OP_IGNORE:
                            begin
                                val_reg   <= krmt_pkg::NOT_FOUND;
                                st_reg    <= krmt_pkg::ST_IGNORED;
                                state_reg <= S_OUT;
                            end
                            default:
                            begin
                                val_reg   <= krmt_pkg::NOT_FOUND;
                                st_reg    <= krmt_pkg::ST_BAD_PACKET;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_KEY:
                begin
                    if (i_reg == '0)
                        i_reg <= i_reg + 1'b1;
                    else
                    begin
                        if (kmatch)
                            kfound_reg <= 1'b1;
                        if (kmatch && in_slice)
                        begin
                            sel_reg   <= ps;
                            off_reg   <= od[EW-1:0];
                            hitk_reg  <= 1'b1;
                            state_reg <= S_IREAD;
                        end
                        else if (i_reg == (SW+1)'(krmt_pkg::TABLE_ENTRIES))
                        begin
                            i_reg     <= '0;
                            state_reg <= S_RANGE;
                        end
                        else
                            i_reg <= i_reg + 1'b1;
                    end
                end
                S_RANGE:
                begin
                    if (i_reg == '0)
                        i_reg <= i_reg + 1'b1;
                    else if (rmatch && have_reg)
                    begin
                        val_reg   <= krmt_pkg::NOT_FOUND;
                        st_reg    <= krmt_pkg::ST_AMBIGUOUS;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        if (rmatch)
                        begin
                            have_reg  <= 1'b1;
                            sel_reg   <= ps;
                            off_reg   <= od[EW-1:0];
                            copyv_reg <= in_slice;
                        end
                        if (i_reg == (SW+1)'(krmt_pkg::TABLE_ENTRIES))
                        begin
                            if (rmatch ? in_slice : (have_reg && copyv_reg))
                                state_reg <= S_IREAD;
                            else
                            begin
                                val_reg   <= krmt_pkg::NOT_FOUND;
                                st_reg    <= kfound_reg ? krmt_pkg::ST_OUT_OF_RANGE
                                                        : krmt_pkg::ST_MISS;
                                state_reg <= S_OUT;
                            end
                        end
                        else
                            i_reg <= i_reg + 1'b1;
                    end
                end
                S_IREAD:
                    state_reg <= S_IWAIT;
                S_IWAIT:
                begin
                    val_reg   <= rd_reg;
                    st_reg    <= hitk_reg ? krmt_pkg::ST_HIT : krmt_pkg::ST_RANGE_HIT;
                    state_reg <= S_OUT;
                end
                S_CSCAN:
                begin
                    if (i_reg == '0)
                        i_reg <= i_reg + 1'b1;
                    else if (kmatch)
                    begin
                        sel_reg   <= ps;
                        st_reg    <= krmt_pkg::ST_REPLACED;
                        k_reg     <= '0;
                        state_reg <= S_COPY;
                    end
                    else
                    begin
                        if (!vld_q && !free_reg)
                        begin
                            free_reg      <= 1'b1;
                            free_slot_reg <= ps;
                        end
                        if (i_reg == (SW+1)'(krmt_pkg::TABLE_ENTRIES))
                        begin
                            k_reg     <= '0;
                            state_reg <= S_COPY;
                            if (free_reg)
                            begin
                                sel_reg <= free_slot_reg;
                                st_reg  <= krmt_pkg::ST_INSERTED;
                            end
                            else if (!vld_q)
                            begin
                                sel_reg <= ps;
                                st_reg  <= krmt_pkg::ST_INSERTED;
                            end
                            else
                            begin
                                sel_reg <= '0;
                                st_reg  <= krmt_pkg::ST_EVICTED;
                            end
                        end
                        else
                            i_reg <= i_reg + 1'b1;
                    end
                end
                S_COPY:
                begin
                    // staging read is registered; write element k-1
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == (CW+1)'(krmt_pkg::MAX_ELEMENTS))
                    begin
                        vld_reg[sel_reg] <= 1'b1;
                        val_reg          <= krmt_pkg::NOT_FOUND;
                        state_reg        <= S_OUT;
                    end
                end
                S_OUT:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
            c_reg <= cmd;
        if (state_reg == S_COPY && k_reg != '0)
            idx_mem[{sel_reg, EW'(k_reg - 1'b1)}] <=
                ((k_reg - 1'b1) < (CW+1)'(c_reg.fill)) ? stg_rdata : 32'd0;
        if (state_reg == S_COPY && k_reg == (CW+1)'(krmt_pkg::MAX_ELEMENTS))
        begin
            key_mem[sel_reg]   <= c_reg.key;
            start_mem[sel_reg] <= c_reg.start;
            cnt_mem[sel_reg]   <= c_reg.count;
        end
        key_q   <= key_mem[ra];
        start_q <= start_mem[ra];
        cnt_q   <= cnt_mem[ra];
        vld_q   <= vld_reg[ra];
        rd_reg  <= idx_mem[{sel_reg, off_reg}];
    end

`ifndef SYNTHESIS
    a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state not one-hot");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(status))
        else $error("result dropped");
    a_copy_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY && k_reg == (CW+1)'(krmt_pkg::MAX_ELEMENTS))
        |=> state_reg == S_OUT)
        else $error("copy overrun");
`endif

endmodule
`default_nettype wire

// File: rtl/keyed_range_mapping_table.sv
`default_nettype none
// Lookup runs a key scan, then a range scan if the key scan finds no hit;
// commit runs a slot scan then a staging copy; bad packet or ignored skip both.
// Throughput: one item at a time in the slot scanner, one slot per cycle.
// Element items are taken every cycle while the queue has room; after a
// committing item input holds until the engine has copied the staging.
// Reset clears slot valid bits and staging fill at once; no clearing pass.
// ----------------------------------------------------------------------------
// keyed_range_mapping_table
// Keyed slot table mapping key and ordinal to streamed index values.
// ----------------------------------------------------------------------------
module keyed_range_mapping_table
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output      logic          s_axis_tready,
    // proxy,entry_count,output_start,element_value,ordinal,
    // packet_start,packet_count (256 bits)
    input  wire logic [255:0]  s_axis_tdata,
    input  wire logic          s_axis_tuser,    // action
    input  wire logic          s_axis_tlast,    // last_element
    output      logic          m_axis_tvalid,
    input  wire logic          m_axis_tready,
    // index_value, status
    output      logic [39:0]   m_axis_tdata
);

    logic                          cv, cr, qv, qr;
    krmt_pkg::cmd_t                cw, qd;
    logic [krmt_pkg::ELEM_W-1:0]   sra;
    logic [31:0]                   srd;
    logic                          rel;
    logic [31:0]                   iv;
    logic [3:0]                    st;

    krmt_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .action(s_axis_tuser), .proxy(s_axis_tdata[63:0]),
        .entry_count(s_axis_tdata[95:64]), .output_start(s_axis_tdata[127:96]),
        .element_value(s_axis_tdata[159:128]), .last_element(s_axis_tlast),
        .ordinal(s_axis_tdata[191:160]), .packet_start(s_axis_tdata[223:192]),
        .packet_count(s_axis_tdata[255:224]),
        .cmd_valid(cv), .cmd_ready(cr), .cmd(cw),
        .stg_raddr(sra), .stg_rdata(srd), .stg_release(rel)
    );

    krmt_queue u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(cv), .wr_ready(cr), .wr_data(cw),
        .rd_valid(qv), .rd_ready(qr), .rd_data(qd)
    );

    krmt_engine u_engine
    (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(qv), .cmd_ready(qr), .cmd(qd),
        .stg_raddr(sra), .stg_rdata(srd), .stg_release(rel),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .index_value(iv), .status(st)
    );

    assign m_axis_tdata = {4'd0, st, iv};

endmodule
`default_nettype wire
